FILE: hw/rtl/dsd_pkg.sv
`default_nettype none

package dsd_pkg;

   // store geometry
   localparam int SLOT_COUNT = 512;
   localparam int ADDR_W     = $clog2(SLOT_COUNT);

   // field widths
   localparam int IDX_W   = 9;
   localparam int VAL_W   = 8;
   localparam int CHAN_W  = 10;
   localparam int LEVEL_W = 10;

   // self-addressing
   localparam logic [VAL_W-1:0]  CFG_MARK    = 8'd254;
   localparam logic [CHAN_W-1:0] CHANNEL_MAX = 10'd512;
   localparam logic [CHAN_W-1:0] CHANNEL_DEF = 10'd1;

   // level thresholds for the fractional part of v*1023/255
   localparam logic [VAL_W-1:0] LVL_STEP1 = 8'd85;
   localparam logic [VAL_W-1:0] LVL_STEP2 = 8'd170;
   localparam logic [VAL_W-1:0] LVL_STEP3 = 8'd255;

   // csr map: register index taken from paddr[2]
   localparam logic REG_START_CHANNEL = 1'b0;

   typedef enum logic {
      CMD_WRITE = 1'b0,
      CMD_EVAL  = 1'b1
   } cmd_type;

   // v*1023/255 = 4v + floor(3v/255), the second term is 0..3
   function automatic logic [LEVEL_W-1:0] slot_level(input logic [VAL_W-1:0] v);
      logic [1:0] corr;
      corr = (v == LVL_STEP3) ? 2'd3 :
             (v >= LVL_STEP2) ? 2'd2 :
             (v >= LVL_STEP1) ? 2'd1 : 2'd0;
      return {v, 2'b00} + {{(LEVEL_W-2){1'b0}}, corr};
   endfunction

   // start channel outside 1..512 falls back to channel 1
   function automatic logic [CHAN_W-1:0] valid_channel(input logic [CHAN_W-1:0] ch);
      return ((ch != '0) && (ch <= CHANNEL_MAX)) ? ch : CHANNEL_DEF;
   endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/dsd_req_if.sv
`default_nettype none

interface dsd_req_if;
   logic                           valid;
   logic                           ready;
   logic                           cmd;
   logic [dsd_pkg::IDX_W-1:0]      slot_index;
   logic [dsd_pkg::VAL_W-1:0]      slot_value;

   modport source (output valid, output cmd, output slot_index, output slot_value,
                   input ready);
   modport sink   (input valid, input cmd, input slot_index, input slot_value,
                   output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/dsd_rsp_if.sv
`default_nettype none

interface dsd_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [dsd_pkg::LEVEL_W-1:0]    dimmer_level;
   logic [dsd_pkg::CHAN_W-1:0]     active_channel;
   logic                           config_mode;
   logic                           save_request;

   modport source (output valid, output dimmer_level, output active_channel,
                   output config_mode, output save_request, input ready);
   modport sink   (input valid, input dimmer_level, input active_channel,
                   input config_mode, input save_request, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/dmx_slot_dimmer_with_self_address_top.sv
`default_nettype none

// channel   direction  protocol        contents
// req_bus   in         valid/ready     cmd, slot_index, slot_value
// rsp_bus   out        valid/ready     dimmer_level, active_channel, config_mode, save_request
// csr_*     in/out     apb, pready=1   start_channel at byte address 0
//
// one transfer per cycle in while req_bus.ready is high; an evaluate's rsp passes through
// (input register, slot memory read register, result register)
// write items give no rsp
// synchronous reset starts a clearing pass over all 512 slots (one slot a cycle)
// during which req_bus.ready is low; csr writes are taken throughout
// rsp stall freezes the whole pipe, so req_bus.ready falls with it

module dmx_slot_dimmer_with_self_address_top (
   input  wire logic        clock,
   input  wire logic        reset,
   dsd_req_if.sink          req_bus,
   dsd_rsp_if.source        rsp_bus,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic      [31:0] csr_prdata,
   output logic             csr_pready
);

   localparam int AW = dsd_pkg::ADDR_W;
   localparam int CW = dsd_pkg::CHAN_W;
   localparam int VW = dsd_pkg::VAL_W;
   localparam int IW = dsd_pkg::IDX_W;

   // slot memory, plus shadow copies of slots 0..3 for self-addressing
   logic [VW-1:0] slot_mem [dsd_pkg::SLOT_COUNT];
   logic [VW-1:0] shadow_ff [4];

   // clearing pass
   logic          clearing_ff;
   logic [AW-1:0] clr_addr_ff;

   // config and channel state
   logic [CW-1:0] start_ff;
   logic [CW-1:0] cur_chan_ff, cur_chan_in;

   // stage 1: input register
   logic              s1_valid_ff;
   dsd_pkg::cmd_type  s1_cmd_ff;
   logic [IW-1:0]     s1_idx_ff;
   logic [VW-1:0]     s1_val_ff;

   // stage 2: memory read register and flags
   logic          s2_valid_ff;
   logic [CW-1:0] s2_chan_ff;
   logic          s2_cfg_ff;
   logic          s2_save_ff;
   logic          s2_beyond_ff;
   logic [VW-1:0] rdata_ff;

   // result register
   logic                          out_valid_ff;
   logic [dsd_pkg::LEVEL_W-1:0]   out_level_ff;
   logic [CW-1:0]                 out_chan_ff;
   logic                          out_cfg_ff;
   logic                          out_save_ff;

   logic          advance;
   logic          csr_wr;
   logic          s1_eval;
   logic          s1_write;
   logic          cfg_hit;
   logic [IW-1:0] new_chan;
   logic          take_new;
   logic [CW-1:0] rd_idx;
   logic          rd_beyond;
   logic          wr_in_range;
   logic [VW-1:0] level_src;

   // whole pipe moves when the result register is free or being emptied
   assign advance        = !out_valid_ff || rsp_bus.ready;
   assign req_bus.ready  = advance && !clearing_ff;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr[2] == dsd_pkg::REG_START_CHANNEL) ?
                       {{(32-CW){1'b0}}, start_ff} : 32'd0;

   assign s1_eval  = s1_valid_ff && (s1_cmd_ff == dsd_pkg::CMD_EVAL);
   assign s1_write = s1_valid_ff && (s1_cmd_ff == dsd_pkg::CMD_WRITE);

   // self-addressing: slots 0 and 1 hold the mark, slots 2 + 3 give the channel
   assign cfg_hit  = (shadow_ff[0] == dsd_pkg::CFG_MARK) &&
                     (shadow_ff[1] == dsd_pkg::CFG_MARK);
   assign new_chan = {1'b0, shadow_ff[2]} + {1'b0, shadow_ff[3]};
   // sum is at most 510, so only the zero case is out of range
   assign take_new = s1_eval && cfg_hit && (new_chan != '0) &&
                     ({1'b0, new_chan} != cur_chan_ff);

   always_comb begin
      cur_chan_in = cur_chan_ff;
      if (csr_wr && (csr_paddr[2] == dsd_pkg::REG_START_CHANNEL)) begin
         cur_chan_in = dsd_pkg::valid_channel(csr_pwdata[CW-1:0]);
      end else if (advance && take_new) begin
         cur_chan_in = {1'b0, new_chan};
      end
   end

   // read address follows the channel this evaluate ends up with
   assign rd_idx      = (take_new ? {1'b0, new_chan} : cur_chan_ff) - CW'(1);
   assign rd_beyond   = rd_idx >= CW'(dsd_pkg::SLOT_COUNT);
   assign wr_in_range = {1'b0, s1_idx_ff} < (IW+1)'(dsd_pkg::SLOT_COUNT);

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff  <= 1'b1;
         clr_addr_ff  <= '0;
         start_ff     <= dsd_pkg::CHANNEL_DEF;
         cur_chan_ff  <= dsd_pkg::CHANNEL_DEF;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         for (int i = 0; i < 4; i++) begin
            shadow_ff[i] <= '0;
         end
      end else begin
         if (clearing_ff) begin
            clr_addr_ff <= clr_addr_ff + AW'(1);
            if (clr_addr_ff == AW'(dsd_pkg::SLOT_COUNT - 1)) begin
               clearing_ff <= 1'b0;
            end
         end
         if (csr_wr && (csr_paddr[2] == dsd_pkg::REG_START_CHANNEL)) begin
            start_ff <= csr_pwdata[CW-1:0];
         end
         cur_chan_ff <= cur_chan_in;
         if (advance) begin
            s1_valid_ff  <= req_bus.valid && req_bus.ready;
            s2_valid_ff  <= s1_eval;
            out_valid_ff <= s2_valid_ff;
            if (s1_write && (s1_idx_ff < IW'(4))) begin
               shadow_ff[s1_idx_ff[1:0]] <= s1_val_ff;
            end
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (advance) begin
         s1_cmd_ff    <= dsd_pkg::cmd_type'(req_bus.cmd);
         s1_idx_ff    <= req_bus.slot_index;
         s1_val_ff    <= req_bus.slot_value;
         s2_chan_ff   <= take_new ? {1'b0, new_chan} : cur_chan_ff;
         s2_cfg_ff    <= cfg_hit;
         s2_save_ff   <= take_new;
         s2_beyond_ff <= rd_beyond;
         out_level_ff <= dsd_pkg::slot_level(level_src);
         out_chan_ff  <= s2_chan_ff;
         out_cfg_ff   <= s2_cfg_ff;
         out_save_ff  <= s2_save_ff;
      end
   end

   // slot memory: one write port shared with the clearing pass, one read port
   always_ff @(posedge clock) begin
      if (clearing_ff) begin
         slot_mem[clr_addr_ff] <= '0;
      end else if (advance && s1_write && wr_in_range) begin
         slot_mem[s1_idx_ff[AW-1:0]] <= s1_val_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rdata_ff <= slot_mem[rd_idx[AW-1:0]];
      end
   end

   // a channel past the end of the store reads as zero
   assign level_src = s2_beyond_ff ? '0 : rdata_ff;

   assign rsp_bus.valid          = out_valid_ff;
   assign rsp_bus.dimmer_level   = out_level_ff;
   assign rsp_bus.active_channel = out_chan_ff;
   assign rsp_bus.config_mode    = out_cfg_ff;
   assign rsp_bus.save_request   = out_save_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/dsd_checker.sv
`default_nettype none

module dsd_checker (
   input wire logic                         clock,
   input wire logic                         reset,
   input wire logic                         req_ready,
   input wire logic                         rsp_valid,
   input wire logic                         rsp_ready,
   input wire logic [dsd_pkg::LEVEL_W-1:0]  rsp_level,
   input wire logic [dsd_pkg::CHAN_W-1:0]   rsp_chan,
   input wire logic                         rsp_cfg,
   input wire logic                         rsp_save
);

   // clearing pass holds off input right after reset
   a_clear_after_reset: assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("req ready during clearing pass");

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_level) &&
                                  $stable(rsp_chan) && $stable(rsp_cfg) && $stable(rsp_save))
      else $error("result changed while stalled");

   a_chan_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_chan != '0) && (rsp_chan <= dsd_pkg::CHANNEL_MAX))
      else $error("active channel out of range");

   a_save_in_cfg: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_save |-> rsp_cfg)
      else $error("save request outside configuration mode");

endmodule

bind dmx_slot_dimmer_with_self_address_top dsd_checker u_dsd_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_bus.ready),
   .rsp_valid (rsp_bus.valid),
   .rsp_ready (rsp_bus.ready),
   .rsp_level (rsp_bus.dimmer_level),
   .rsp_chan  (rsp_bus.active_channel),
   .rsp_cfg   (rsp_bus.config_mode),
   .rsp_save  (rsp_bus.save_request)
);

`default_nettype wire
